### rtl/raw_pkg.sv
// ----------------------------------------------------------------------------
// Room admission wait list: shared types and constants
// Request/result structs, mode and status codes, controller states, defaults.
// ----------------------------------------------------------------------------
package raw_pkg;

  localparam int unsigned DEF_NUM_ROOMS   = 8;
  localparam int unsigned DEF_MAX_MEMBERS = 16;
  localparam int unsigned DEF_QUEUE_DEPTH = 32;
  localparam int unsigned DEF_NUM_CLIENTS = 64;

  localparam int unsigned ROOM_W   = 3;
  localparam int unsigned CLIENT_W = 6;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned CAP_W    = 5;

  localparam logic [CAP_W-1:0] DEFAULT_CAPACITY = 5'd3;

  typedef enum logic [1:0] {
    MODE_JOIN,
    MODE_LEAVE,
    MODE_DISC,
    MODE_QUERY
  } mode_t;

  typedef enum logic [3:0] {
    ST_JOINED,
    ST_ALREADY,
    ST_STILL_WAIT,
    ST_QUEUED,
    ST_FULL,
    ST_NOT_IN,
    ST_WRONG_ROOM,
    ST_LEFT,
    ST_DISCONNECTED,
    ST_IN_ROOM,
    ST_WAITING,
    ST_IDLE,
    ST_PROMOTED
  } status_t;

  typedef struct packed {
    mode_t               mode;
    logic [ROOM_W-1:0]   room;
    logic [CLIENT_W-1:0] client;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [ROOM_W-1:0]   room_out;
    logic [CLIENT_W-1:0] client_out;
    logic [POS_W-1:0]    position;
    logic                last;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FREE,
    S_PROMO_RD,
    S_PROMO_CMP,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_HIT,
    S_MISS,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_EMIT1,
    S_EMIT2
  } state_t;

endpackage

### rtl/raw_ram.sv
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module raw_ram #(
  parameter int unsigned W = 6,
  parameter int unsigned D = 256,
  parameter int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/room_admission_waitlist.sv
// ----------------------------------------------------------------------------
// Room admission with per-room FIFO wait lists
// Join/leave/disconnect/query requests against fixed rooms, with promotion
// of the oldest eligible waiter when a slot frees up.
// ----------------------------------------------------------------------------
// Some requests are decided in decode alone; join and waiting-list query
//   add a read and a compare per live entry of each room scanned.
// Disconnect scans all rooms, shifting the tail over a purged entry, and
//   for a joined client first walks the promotion in its room.
// One request at a time: busy until its last result is loaded;
//   results cannot be stalled. Reset: synchronous, flags clear, capacity 3.
// ----------------------------------------------------------------------------
module room_admission_waitlist #(
  parameter int unsigned NUM_ROOMS   = raw_pkg::DEF_NUM_ROOMS,
  parameter int unsigned MAX_MEMBERS = raw_pkg::DEF_MAX_MEMBERS,
  parameter int unsigned QUEUE_DEPTH = raw_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned NUM_CLIENTS = raw_pkg::DEF_NUM_CLIENTS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  raw_pkg::req_t              request,
  input  logic                       cfg_we,
  input  logic [raw_pkg::CAP_W-1:0]  cfg_data,
  output logic                       strobe,
  output raw_pkg::res_t              result
);
  import raw_pkg::*;

  // index widths
  localparam int unsigned RIW = (NUM_ROOMS > 1) ? $clog2(NUM_ROOMS) : 1;
  localparam int unsigned CIW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int unsigned QIW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QLW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QSW = QLW + 1;
  localparam int unsigned MCW = $clog2(MAX_MEMBERS + 1);
  localparam int unsigned WAD = NUM_ROOMS * QUEUE_DEPTH;
  localparam int unsigned WAW = $clog2(WAD);

  // control state
  state_t state, state_next;
  logic [CAP_W-1:0]   cap;
  logic [MCW-1:0]     cnt   [NUM_ROOMS];
  logic [QIW-1:0]     head  [NUM_ROOMS];
  logic [QLW-1:0]     qlen  [NUM_ROOMS];
  logic [NUM_CLIENTS-1:0] joined;   // doubles as valid bit for client_room RAM
  logic               have_promo;

  // request context
  req_t               req_q;
  logic [RIW-1:0]     cur_room;
  logic [QLW-1:0]     k;
  res_t               pend;
  res_t               promo;

  // RAM ports
  logic               cr_we;
  logic [CIW-1:0]     cr_waddr;
  logic [RIW-1:0]     cr_wdata;
  logic               cr_re;
  logic [RIW-1:0]     cr_rdata;
  logic               wr_we;
  logic [WAW-1:0]     wr_waddr;
  logic [CLIENT_W-1:0] wr_wdata;
  logic               wr_re;
  logic [WAW-1:0]     wr_raddr;
  logic [CLIENT_W-1:0] wr_rdata;

  // actions from the sequencer
  logic               accept;
  logic               emit;
  res_t               emit_res;
  logic               room_ld;
  logic [RIW-1:0]     room_val;
  logic               k_clr, k_inc;
  logic               cnt_inc, cnt_dec, head_adv, len_inc, len_dec;
  logic               jn_we, jn_val;
  logic [CIW-1:0]     jn_idx;
  logic               pend_we, promo_we, promo_clr;
  res_t               pend_val, promo_val;

  // current-room views
  logic [MCW-1:0]     cnt_cur;
  logic [QIW-1:0]     head_cur;
  logic [QLW-1:0]     qlen_cur;
  logic               room_free;
  logic               waiter_ok;
  logic               last_room;
  logic [CIW-1:0]     req_idx;

  function automatic logic [QIW-1:0] slot_of(input logic [QIW-1:0] h,
                                             input logic [QLW-1:0] off);
    logic [QSW-1:0] sum;
    sum = QSW'(h) + QSW'(off);
    if (sum >= QSW'(QUEUE_DEPTH)) begin
      sum = sum - QSW'(QUEUE_DEPTH);
    end
    return QIW'(sum);
  endfunction

  function automatic logic [WAW-1:0] addr_of(input logic [RIW-1:0] r,
                                             input logic [QIW-1:0] s);
    return WAW'(r) * WAW'(QUEUE_DEPTH) + WAW'(s);
  endfunction

  function automatic res_t mk(input status_t st, input logic [ROOM_W-1:0] r,
                              input logic [CLIENT_W-1:0] c,
                              input logic [POS_W-1:0] p, input logic l);
    res_t x;
    x.status     = st;
    x.room_out   = r;
    x.client_out = c;
    x.position   = p;
    x.last       = l;
    return x;
  endfunction

  // client -> room of membership; read data used only where the joined flag is set
  raw_ram #(.W(RIW), .D(NUM_CLIENTS)) u_client_room (
    .clk   (clk),
    .we    (cr_we),
    .waddr (cr_waddr),
    .wdata (cr_wdata),
    .re    (cr_re),
    .raddr (CIW'(request.client)),
    .rdata (cr_rdata)
  );

  // per-room circular wait lists, rooms laid out back to back
  raw_ram #(.W(CLIENT_W), .D(WAD)) u_wait_ids (
    .clk   (clk),
    .we    (wr_we),
    .waddr (wr_waddr),
    .wdata (wr_wdata),
    .re    (wr_re),
    .raddr (wr_raddr),
    .rdata (wr_rdata)
  );

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign cr_re    = accept;
  assign cnt_cur  = cnt[cur_room];
  assign head_cur = head[cur_room];
  assign qlen_cur = qlen[cur_room];
  assign req_idx  = CIW'(req_q.client);
  // free slot against min(capacity register, MAX_MEMBERS)
  assign room_free = (32'(cnt_cur) < 32'(cap)) && (32'(cnt_cur) < MAX_MEMBERS);
  // waiter already joined elsewhere (or out of range) gets dropped
  assign waiter_ok = (32'(wr_rdata) < NUM_CLIENTS) && !joined[CIW'(wr_rdata)];
  assign last_room = (32'(cur_room) == NUM_ROOMS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and actions
  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_res   = res_t'('0);
    room_ld    = 1'b0;
    room_val   = cur_room;
    k_clr      = 1'b0;
    k_inc      = 1'b0;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    head_adv   = 1'b0;
    len_inc    = 1'b0;
    len_dec    = 1'b0;
    jn_we      = 1'b0;
    jn_val     = 1'b0;
    jn_idx     = req_idx;
    cr_we      = 1'b0;
    cr_waddr   = req_idx;
    cr_wdata   = cur_room;
    wr_we      = 1'b0;
    wr_waddr   = addr_of(cur_room, slot_of(head_cur, k));
    wr_wdata   = req_q.client;
    wr_re      = 1'b0;
    wr_raddr   = addr_of(cur_room, slot_of(head_cur, k));
    pend_we    = 1'b0;
    pend_val   = res_t'('0);
    promo_we   = 1'b0;
    promo_clr  = 1'b0;
    promo_val  = res_t'('0);

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (32'(request.client) < NUM_CLIENTS) begin
            state_next = S_DECODE;
          end else begin
            emit     = 1'b1;
            emit_res = mk(ST_IDLE, '0, request.client, '0, 1'b1);
          end
        end
      end

      S_DECODE: begin
        unique case (req_q.mode)
          MODE_JOIN: begin
            if (joined[req_idx]) begin
              emit       = 1'b1;
              emit_res   = mk(ST_ALREADY, ROOM_W'(cr_rdata), req_q.client, '0, 1'b1);
              state_next = S_IDLE;
            end else if (32'(req_q.room) >= NUM_ROOMS) begin
              emit       = 1'b1;
              emit_res   = mk(ST_WRONG_ROOM, req_q.room, req_q.client, '0, 1'b1);
              state_next = S_IDLE;
            end else begin
              room_ld    = 1'b1;
              room_val   = RIW'(req_q.room);
              k_clr      = 1'b1;
              state_next = S_SCAN_RD;
            end
          end
          MODE_LEAVE: begin
            if (!joined[req_idx]) begin
              emit       = 1'b1;
              emit_res   = mk(ST_NOT_IN, req_q.room, req_q.client, '0, 1'b1);
              state_next = S_IDLE;
            end else if (32'(req_q.room) >= NUM_ROOMS) begin
              emit       = 1'b1;
              emit_res   = mk(ST_WRONG_ROOM, req_q.room, req_q.client, '0, 1'b1);
              state_next = S_IDLE;
            end else if (32'(cr_rdata) != 32'(req_q.room)) begin
              emit       = 1'b1;
              emit_res   = mk(ST_WRONG_ROOM, ROOM_W'(cr_rdata), req_q.client, '0, 1'b1);
              state_next = S_IDLE;
            end else begin
              room_ld    = 1'b1;
              room_val   = cr_rdata;
              pend_we    = 1'b1;
              pend_val   = mk(ST_LEFT, ROOM_W'(cr_rdata), req_q.client, '0, 1'b0);
              promo_clr  = 1'b1;
              state_next = S_FREE;
            end
          end
          MODE_DISC: begin
            promo_clr = 1'b1;
            pend_we   = 1'b1;
            room_ld   = 1'b1;
            if (joined[req_idx]) begin
              room_val   = cr_rdata;
              pend_val   = mk(ST_DISCONNECTED, ROOM_W'(cr_rdata), req_q.client, '0, 1'b0);
              state_next = S_FREE;
            end else begin
              room_val   = '0;
              pend_val   = mk(ST_DISCONNECTED, '0, req_q.client, '0, 1'b0);
              k_clr      = 1'b1;
              state_next = S_SCAN_RD;
            end
          end
          MODE_QUERY: begin
            if (joined[req_idx]) begin
              emit       = 1'b1;
              emit_res   = mk(ST_IN_ROOM, ROOM_W'(cr_rdata), req_q.client, '0, 1'b1);
              state_next = S_IDLE;
            end else begin
              room_ld    = 1'b1;
              room_val   = '0;
              k_clr      = 1'b1;
              state_next = S_SCAN_RD;
            end
          end
        endcase
      end

      // release the slot; a leaving client drops its flag before promotion
      S_FREE: begin
        cnt_dec = (cnt_cur != '0);
        if (req_q.mode == MODE_LEAVE) begin
          jn_we = 1'b1;
        end
        state_next = S_PROMO_RD;
      end

      S_PROMO_RD: begin
        if (room_free && (qlen_cur != '0)) begin
          wr_re      = 1'b1;
          wr_raddr   = addr_of(cur_room, head_cur);
          state_next = S_PROMO_CMP;
        end else if (req_q.mode == MODE_LEAVE) begin
          state_next = S_EMIT1;
        end else begin
          room_ld    = 1'b1;
          room_val   = '0;
          k_clr      = 1'b1;
          state_next = S_SCAN_RD;
        end
      end

      S_PROMO_CMP: begin
        head_adv = 1'b1;
        len_dec  = 1'b1;
        if (waiter_ok) begin
          jn_we     = 1'b1;
          jn_val    = 1'b1;
          jn_idx    = CIW'(wr_rdata);
          cr_we     = 1'b1;
          cr_waddr  = CIW'(wr_rdata);
          cnt_inc   = 1'b1;
          promo_we  = 1'b1;
          promo_val = mk(ST_PROMOTED, ROOM_W'(cur_room), wr_rdata, '0, 1'b1);
          if (req_q.mode == MODE_LEAVE) begin
            state_next = S_EMIT1;
          end else begin
            room_ld    = 1'b1;
            room_val   = '0;
            k_clr      = 1'b1;
            state_next = S_SCAN_RD;
          end
        end else begin
          state_next = S_PROMO_RD;
        end
      end

      S_SCAN_RD: begin
        if (k < qlen_cur) begin
          wr_re      = 1'b1;
          state_next = S_SCAN_CMP;
        end else begin
          state_next = S_MISS;
        end
      end

      S_SCAN_CMP: begin
        if (wr_rdata == req_q.client) begin
          state_next = S_HIT;
        end else begin
          k_inc      = 1'b1;
          state_next = S_SCAN_RD;
        end
      end

      S_HIT: begin
        case (req_q.mode)
          MODE_JOIN: begin
            emit       = 1'b1;
            emit_res   = mk(ST_STILL_WAIT, ROOM_W'(cur_room), req_q.client,
                            POS_W'(32'(k) + 1), 1'b1);
            state_next = S_IDLE;
          end
          MODE_QUERY: begin
            emit       = 1'b1;
            emit_res   = mk(ST_WAITING, ROOM_W'(cur_room), req_q.client,
                            POS_W'(32'(k) + 1), 1'b1);
            state_next = S_IDLE;
          end
          MODE_DISC: begin
            state_next = S_SHIFT_RD;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end

      S_MISS: begin
        case (req_q.mode)
          MODE_JOIN: begin
            state_next = S_IDLE;
            emit       = 1'b1;
            if (room_free) begin
              cnt_inc  = 1'b1;
              jn_we    = 1'b1;
              jn_val   = 1'b1;
              cr_we    = 1'b1;
              emit_res = mk(ST_JOINED, ROOM_W'(cur_room), req_q.client, '0, 1'b1);
            end else if (32'(qlen_cur) >= QUEUE_DEPTH) begin
              emit_res = mk(ST_FULL, ROOM_W'(cur_room), req_q.client, '0, 1'b1);
            end else begin
              wr_we    = 1'b1;
              wr_waddr = addr_of(cur_room, slot_of(head_cur, qlen_cur));
              len_inc  = 1'b1;
              emit_res = mk(ST_QUEUED, ROOM_W'(cur_room), req_q.client,
                            POS_W'(32'(qlen_cur) + 1), 1'b1);
            end
          end
          MODE_QUERY: begin
            if (last_room) begin
              emit       = 1'b1;
              emit_res   = mk(ST_IDLE, '0, req_q.client, '0, 1'b1);
              state_next = S_IDLE;
            end else begin
              room_ld    = 1'b1;
              room_val   = cur_room + 1'b1;
              k_clr      = 1'b1;
              state_next = S_SCAN_RD;
            end
          end
          MODE_DISC: begin
            if (last_room) begin
              jn_we      = 1'b1;
              state_next = S_EMIT1;
            end else begin
              room_ld    = 1'b1;
              room_val   = cur_room + 1'b1;
              k_clr      = 1'b1;
              state_next = S_SCAN_RD;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end

      // close the gap left by a purged entry, moving each later entry down one slot
      S_SHIFT_RD: begin
        if (32'(k) + 1 < 32'(qlen_cur)) begin
          wr_re      = 1'b1;
          wr_raddr   = addr_of(cur_room, slot_of(head_cur, QLW'(32'(k) + 1)));
          state_next = S_SHIFT_WR;
        end else begin
          len_dec = 1'b1;
          if (last_room) begin
            jn_we      = 1'b1;
            state_next = S_EMIT1;
          end else begin
            room_ld    = 1'b1;
            room_val   = cur_room + 1'b1;
            k_clr      = 1'b1;
            state_next = S_SCAN_RD;
          end
        end
      end

      S_SHIFT_WR: begin
        wr_we      = 1'b1;
        wr_wdata   = wr_rdata;
        k_inc      = 1'b1;
        state_next = S_SHIFT_RD;
      end

      S_EMIT1: begin
        emit          = 1'b1;
        emit_res      = pend;
        emit_res.last = !have_promo;
        state_next    = have_promo ? S_EMIT2 : S_IDLE;
      end

      S_EMIT2: begin
        emit       = 1'b1;
        emit_res   = promo;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cap        <= DEFAULT_CAPACITY;
      joined     <= '0;
      strobe     <= 1'b0;
      have_promo <= 1'b0;
      for (int i = 0; i < NUM_ROOMS; i++) begin
        cnt[i]  <= '0;
        head[i] <= '0;
        qlen[i] <= '0;
      end
    end else begin
      strobe <= emit;
      if (cfg_we) begin
        cap <= cfg_data;
      end
      if (jn_we) begin
        joined[jn_idx] <= jn_val;
      end
      if (cnt_inc) begin
        cnt[cur_room] <= cnt_cur + 1'b1;
      end else if (cnt_dec) begin
        cnt[cur_room] <= cnt_cur - 1'b1;
      end
      if (head_adv) begin
        head[cur_room] <= slot_of(head_cur, QLW'(1));
      end
      if (len_inc) begin
        qlen[cur_room] <= qlen_cur + 1'b1;
      end else if (len_dec) begin
        qlen[cur_room] <= qlen_cur - 1'b1;
      end
      if (promo_clr) begin
        have_promo <= 1'b0;
      end else if (promo_we) begin
        have_promo <= 1'b1;
      end
    end
  end

  // request context and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= request;
    end
    if (room_ld) begin
      cur_room <= room_val;
    end
    if (k_clr) begin
      k <= '0;
    end else if (k_inc) begin
      k <= k + 1'b1;
    end
    if (pend_we) begin
      pend <= pend_val;
    end
    if (promo_we) begin
      promo <= promo_val;
    end
    if (emit) begin
      result <= emit_res;
    end
  end

  // a non-final result is always followed by the next one
  a_pair_back_to_back: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe)
    else $error("result pair split");

  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN_CMP |-> $past(state) == S_SCAN_RD)
    else $error("scan compare without read");

  a_promo_order: assert property (@(posedge clk) disable iff (rst)
    state == S_PROMO_CMP |-> $past(state) == S_PROMO_RD)
    else $error("promotion compare without read");

  a_emit2_has_promo: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT2 |-> have_promo && $past(state) == S_EMIT1)
    else $error("promotion result without promotion");

endmodule
